// File: design/pairwise_posting_cooccurrence_counter_assert.svh
// Assertion macros used by the co-occurrence counter top level.
`ifndef PAIRWISE_POSTING_COOCCURRENCE_COUNTER_ASSERT_SVH
`define PAIRWISE_POSTING_COOCCURRENCE_COUNTER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: design/ppcc_pkg.sv
// Shared types and codes for the co-occurrence counter.
package ppcc_pkg;
  typedef enum logic [2:0] {
    CMD_NEW_QUERY = 3'd0,
    CMD_ADD_REL   = 3'd1,
    CMD_BEGIN     = 3'd2,
    CMD_ADD_POST  = 3'd3,
    CMD_COMPUTE   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR,
    ST_REQ,
    ST_WAIT,
    ST_STEP,
    ST_EMIT
  } state_t;

  localparam int unsigned DocW = 32;
  localparam int unsigned CntW = 9;
  localparam logic [CntW-1:0] CntMax = '1;
endpackage

// File: design/pairwise_posting_cooccurrence_counter.sv
// Top level: list loader, list memories and three-way merge sequencer.
// Load commands (new query, add relevant, begin concept, add posting) are taken while busy is low.
// Compute: per pair a setup state, then merge steps (fetch list i, fetch list j, step), an end check, emit.
// Merge steps per pair are at most len(i)+len(j)+len(relevant); one list-memory read port bounds it.
// busy rises on a compute with two or more concepts and falls as the final pair's strobe rises; no result stalls.
// Synchronous reset clears lengths, counts, query id and the overflow flag.
module pairwise_posting_cooccurrence_counter #(
  parameter int unsigned MAX_CONCEPTS = 8,
  parameter int unsigned MAX_POSTINGS = 1024,
  parameter int unsigned MAX_RELEVANT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [31:0] query_id,
  input  logic [31:0] doc_id,
  input  logic [31:0] concept_id,
  input  logic [3:0]  concept_type,
  output logic        strobe,
  output logic [31:0] out_query_id,
  output logic [3:0]  first_type,
  output logic [31:0] first_concept,
  output logic [3:0]  second_type,
  output logic [31:0] second_concept,
  output logic [8:0]  both_count,
  output logic [8:0]  first_count,
  output logic [8:0]  second_count,
  output logic        overflow,
  output logic        last
);
  import ppcc_pkg::*;
  `include "pairwise_posting_cooccurrence_counter_assert.svh"

  localparam int unsigned CW  = $clog2(MAX_CONCEPTS);
  localparam int unsigned CCW = $clog2(MAX_CONCEPTS + 1);
  localparam int unsigned PW  = (MAX_POSTINGS > 1) ? $clog2(MAX_POSTINGS) : 1;
  localparam int unsigned PLW = $clog2(MAX_POSTINGS + 1);
  localparam int unsigned RW  = (MAX_RELEVANT > 1) ? $clog2(MAX_RELEVANT) : 1;
  localparam int unsigned RLW = $clog2(MAX_RELEVANT + 1);
  localparam int unsigned PD  = MAX_CONCEPTS * MAX_POSTINGS;
  localparam int unsigned PAW = $clog2(PD);
  localparam int unsigned CDW = (MAX_CONCEPTS > 1) ? CW : 1;

  // control and load state
  state_t             state, state_next;
  logic [RLW-1:0]     rel_len;
  logic [PLW-1:0]     post_len [MAX_CONCEPTS];
  logic [31:0]        cids [MAX_CONCEPTS];
  logic [3:0]         ctypes [MAX_CONCEPTS];
  logic [CCW-1:0]     ccount;
  logic [31:0]        cur_query;
  logic               ovf;
  logic               copen;

  // merge registers
  logic [CDW-1:0]     pi, pj;
  logic [PLW-1:0]     p1, p2;
  logic [RLW-1:0]     t;
  logic [CntW-1:0]    r12, r1, r2;
  logic [1:0]         phase;   // which list is being fetched in ST_REQ/ST_WAIT
  logic [DocW-1:0]    va, vb;

  logic accept;
  cmd_t cmd;
  assign accept = start && !busy;
  assign cmd    = cmd_t'(command);
  assign busy   = (state != ST_IDLE);

  logic [CDW-1:0] last_c;
  assign last_c = CDW'(ccount - CCW'(1));

  // posting memory: one read port shared by list i and list j
  logic            pwe;
  logic [PAW-1:0]  pwaddr, praddr;
  logic [DocW-1:0] prdata;
  logic            rwe;
  logic [RW-1:0]   rwaddr, rraddr;
  logic [DocW-1:0] rrdata;

  assign pwe    = accept && cmd == CMD_ADD_POST && copen &&
                  post_len[last_c] < PLW'(MAX_POSTINGS);
  assign pwaddr = PAW'(PAW'(last_c) * PAW'(MAX_POSTINGS) + PAW'(post_len[last_c][PW-1:0]));
  assign rwe    = accept && cmd == CMD_ADD_REL && rel_len < RLW'(MAX_RELEVANT);
  assign rwaddr = rel_len[RW-1:0];

  ppcc_ram #(.WIDTH(DocW), .DEPTH(PD)) u_post (
    .clk(clk), .we(pwe), .waddr(pwaddr), .wdata(doc_id), .raddr(praddr), .rdata(prdata)
  );
  ppcc_ram #(.WIDTH(DocW), .DEPTH(MAX_RELEVANT)) u_rel (
    .clk(clk), .we(rwe), .waddr(rwaddr), .wdata(doc_id), .raddr(rraddr), .rdata(rrdata)
  );

  // read addresses: phase 0 fetches list i (and relevant), phase 1 list j
  always_comb begin
    if (phase == 2'd0) begin
      praddr = PAW'(PAW'(pi) * PAW'(MAX_POSTINGS) + PAW'(p1[PW-1:0]));
    end else begin
      praddr = PAW'(PAW'(pj) * PAW'(MAX_POSTINGS) + PAW'(p2[PW-1:0]));
    end
    rraddr = t[RW-1:0];
  end

  // availability of each list
  logic have1, have2, havet;
  assign have1 = p1 < post_len[pi];
  assign have2 = p2 < post_len[pj];
  assign havet = t < rel_len;
  logic active;
  assign active = havet && ((have1 && have2) || have1 || have2);

  // merge step decisions (missing list treated as absent)
  logic adv1, adv2, advt, hit1, hit2;
  always_comb begin
    adv1 = 1'b0; adv2 = 1'b0; advt = 1'b0; hit1 = 1'b0; hit2 = 1'b0;
    if (have1 && have2) begin
      if (va < vb && va < rrdata) adv1 = 1'b1;
      else if (vb < va && vb < rrdata) adv2 = 1'b1;
      else if (rrdata < va && rrdata < vb) advt = 1'b1;
      else if (va == vb && va < rrdata) begin adv1 = 1'b1; adv2 = 1'b1; end
      else if (va == rrdata && va < vb) begin adv1 = 1'b1; advt = 1'b1; hit1 = 1'b1; end
      else if (vb == rrdata && vb < va) begin adv2 = 1'b1; advt = 1'b1; hit2 = 1'b1; end
      else begin
        adv1 = 1'b1; adv2 = 1'b1; advt = 1'b1; hit1 = 1'b1; hit2 = 1'b1;
      end
    end else if (have1) begin
      if (va < rrdata) adv1 = 1'b1;
      else if (va > rrdata) advt = 1'b1;
      else begin adv1 = 1'b1; advt = 1'b1; hit1 = 1'b1; end
    end else begin
      if (vb < rrdata) adv2 = 1'b1;
      else if (vb > rrdata) advt = 1'b1;
      else begin adv2 = 1'b1; advt = 1'b1; hit2 = 1'b1; end
    end
  end

  logic last_pair;
  assign last_pair = (CCW'(pj) == ccount - CCW'(1)) && (CCW'(pi) == ccount - CCW'(2));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_COMPUTE && ccount >= CCW'(2)) state_next = ST_PAIR;
      end
      ST_PAIR: state_next = ST_REQ;
      ST_REQ:  state_next = active ? ST_WAIT : ST_EMIT;
      ST_WAIT: state_next = (phase == 2'd1) ? ST_STEP : ST_REQ;
      ST_STEP: state_next = ST_REQ;
      ST_EMIT: state_next = last_pair ? ST_IDLE : ST_PAIR;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // load-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      rel_len <= '0; ccount <= '0; cur_query <= '0; ovf <= 1'b0; copen <= 1'b0;
      for (int k = 0; k < MAX_CONCEPTS; k++) post_len[k] <= '0;
    end else if (accept) begin
      case (cmd)
        CMD_NEW_QUERY: begin
          rel_len <= '0; ccount <= '0; ovf <= 1'b0; copen <= 1'b0; cur_query <= query_id;
          for (int k = 0; k < MAX_CONCEPTS; k++) post_len[k] <= '0;
        end
        CMD_ADD_REL: begin
          if (rwe) rel_len <= rel_len + RLW'(1);
          else ovf <= 1'b1;
        end
        CMD_BEGIN: begin
          if (ccount < CCW'(MAX_CONCEPTS)) begin
            post_len[CDW'(ccount)] <= '0;
            ccount <= ccount + CCW'(1);
            copen  <= 1'b1;
          end else begin
            ovf <= 1'b1; copen <= 1'b0;
          end
        end
        CMD_ADD_POST: begin
          if (pwe) post_len[last_c] <= post_len[last_c] + PLW'(1);
          else if (copen) ovf <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // concept table payload
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_BEGIN && ccount < CCW'(MAX_CONCEPTS)) begin
      cids[CDW'(ccount)]   <= concept_id;
      ctypes[CDW'(ccount)] <= concept_type;
    end
  end

  // merge datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pi <= '0; pj <= '0; phase <= 2'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          pi <= '0; pj <= CDW'(1); phase <= 2'd0;
        end
        ST_PAIR: begin
          p1 <= '0; p2 <= '0; t <= '0; r12 <= '0; r1 <= '0; r2 <= '0; phase <= 2'd0;
        end
        ST_REQ: ;
        ST_WAIT: begin
          if (phase == 2'd0) va <= prdata;
          else vb <= prdata;
          phase <= (phase == 2'd0) ? 2'd1 : 2'd0;
        end
        ST_STEP: begin
          if (adv1) p1 <= p1 + PLW'(1);
          if (adv2) p2 <= p2 + PLW'(1);
          if (advt) t <= t + RLW'(1);
          if (hit1 && hit2 && r12 != CntMax) r12 <= r12 + CntW'(1);
          if (hit1 && r1 != CntMax) r1 <= r1 + CntW'(1);
          if (hit2 && r2 != CntMax) r2 <= r2 + CntW'(1);
        end
        ST_EMIT: begin
          if (CCW'(pj) == ccount - CCW'(1)) begin
            pi <= pi + CDW'(1);
            pj <= pi + CDW'(2);
          end else begin
            pj <= pj + CDW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == ST_EMIT);
    end
    if (state == ST_EMIT) begin
      out_query_id   <= cur_query;
      first_type     <= ctypes[pi];
      first_concept  <= cids[pi];
      second_type    <= ctypes[pj];
      second_concept <= cids[pj];
      both_count     <= r12;
      first_count    <= r1;
      second_count   <= r2;
      overflow       <= ovf;
      last           <= last_pair;
    end
  end

  `PPC_ASSERT_IMP(a_pair_order, state != ST_IDLE, pi < pj, "pair order broken")
  `PPC_ASSERT_NXT(a_strobe_emit, state == ST_EMIT, strobe, "missing result strobe")
  `PPC_ASSERT_IMP(a_busy_strobe, strobe && !last, busy, "idle before last pair")
  `PPC_ASSERT_IMP(a_rel_bound, 1'b1, rel_len <= RLW'(MAX_RELEVANT), "relevant length overrun")
endmodule

// File: design/ppcc_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module ppcc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: verif/tb_top.sv
// Testbench for the pairwise posting co-occurrence counter: directed and random command words, scoreboard check.
class cooc_scoreboard;
  // shadow of the block's store
  logic [31:0] rel_docs[256];
  int unsigned rel_len;
  logic [31:0] post_docs[8][1024];
  int unsigned post_len[8];
  logic [31:0] cids[8];
  logic [3:0]  ctypes[8];
  int unsigned ccount;
  logic [31:0] cur_query;
  bit          ovf;
  bit          open;
  // pending pair results, one entry per pair in each field queue
  logic [31:0] pend_q[$], pend_c1[$], pend_c2[$];
  logic [3:0]  pend_t1[$], pend_t2[$];
  logic [8:0]  pend_both[$], pend_n1[$], pend_n2[$];
  bit          pend_ovf[$], pend_last[$];
  int          errors;

  function new();
    clear_query();
    cur_query = '0;
    errors = 0;
  endfunction

  function void clear_query();
    rel_len = 0;
    foreach (post_len[k]) post_len[k] = 0;
    ccount = 0;
    ovf = 0;
    open = 0;
  endfunction

  function logic [8:0] sat(int unsigned v);
    return (v > 511) ? 9'd511 : v[8:0];
  endfunction

  // three-way merge of list i, list j and the relevant list
  function void merge_counts(int i, int j, output int unsigned r12, output int unsigned r1,
                             output int unsigned r2);
    int unsigned p1, p2, t;
    logic [31:0] a, b, d;
    p1 = 0; p2 = 0; t = 0; r12 = 0; r1 = 0; r2 = 0;
    while (p1 < post_len[i] && p2 < post_len[j] && t < rel_len) begin
      a = post_docs[i][p1]; b = post_docs[j][p2]; d = rel_docs[t];
      if (a < b && a < d) p1++;
      else if (b < a && b < d) p2++;
      else if (d < a && d < b) t++;
      else if (a == b && a < d) begin p1++; p2++; end
      else if (a == d && a < b) begin r1++; p1++; t++; end
      else if (b == d && b < a) begin r2++; p2++; t++; end
      else begin r1++; r2++; r12++; p1++; p2++; t++; end
    end
    while (p1 < post_len[i] && t < rel_len) begin
      a = post_docs[i][p1]; d = rel_docs[t];
      if (a < d) p1++;
      else if (a > d) t++;
      else begin r1++; p1++; t++; end
    end
    while (p2 < post_len[j] && t < rel_len) begin
      b = post_docs[j][p2]; d = rel_docs[t];
      if (b < d) p2++;
      else if (b > d) t++;
      else begin r2++; p2++; t++; end
    end
  endfunction

  // note one accepted command word
  function void note_word(logic [2:0] cmd, logic [31:0] qid, logic [31:0] doc,
                          logic [31:0] cid, logic [3:0] ctype);
    int unsigned b12, b1, b2;
    case (cmd)
      ppcc_pkg::CMD_NEW_QUERY: begin
        clear_query();
        cur_query = qid;
      end
      ppcc_pkg::CMD_ADD_REL: begin
        if (rel_len < 256) begin rel_docs[rel_len] = doc; rel_len++; end
        else ovf = 1;
      end
      ppcc_pkg::CMD_BEGIN: begin
        if (ccount < 8) begin
          cids[ccount] = cid; ctypes[ccount] = ctype; post_len[ccount] = 0;
          ccount++; open = 1;
        end else begin
          ovf = 1; open = 0;
        end
      end
      ppcc_pkg::CMD_ADD_POST: begin
        if (open && ccount > 0) begin
          if (post_len[ccount-1] < 1024) begin
            post_docs[ccount-1][post_len[ccount-1]] = doc;
            post_len[ccount-1]++;
          end else ovf = 1;
        end
      end
      ppcc_pkg::CMD_COMPUTE: begin
        for (int i = 0; i < ccount; i++)
          for (int j = i + 1; j < ccount; j++) begin
            merge_counts(i, j, b12, b1, b2);
            pend_q.push_back(cur_query);
            pend_t1.push_back(ctypes[i]); pend_c1.push_back(cids[i]);
            pend_t2.push_back(ctypes[j]); pend_c2.push_back(cids[j]);
            pend_both.push_back(sat(b12)); pend_n1.push_back(sat(b1));
            pend_n2.push_back(sat(b2));
            pend_ovf.push_back(ovf);
            pend_last.push_back(i == ccount - 2);
          end
      end
      default: ;
    endcase
  endfunction

  function int pending();
    return pend_q.size();
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // compare one result word with the oldest expectation
  task check_word(logic [31:0] q, logic [3:0] t1, logic [31:0] c1, logic [3:0] t2,
                  logic [31:0] c2, logic [8:0] nb, logic [8:0] n1, logic [8:0] n2,
                  logic o, logic l);
    if (pend_q.size() == 0) begin
      report("unexpected result word", 0, 0);
      return;
    end
    if (q !== pend_q[0]) report("out_query_id", q, pend_q[0]);
    if (t1 !== pend_t1[0]) report("first_type", t1, pend_t1[0]);
    if (c1 !== pend_c1[0]) report("first_concept", c1, pend_c1[0]);
    if (t2 !== pend_t2[0]) report("second_type", t2, pend_t2[0]);
    if (c2 !== pend_c2[0]) report("second_concept", c2, pend_c2[0]);
    if (nb !== pend_both[0]) report("both_count", nb, pend_both[0]);
    if (n1 !== pend_n1[0]) report("first_count", n1, pend_n1[0]);
    if (n2 !== pend_n2[0]) report("second_count", n2, pend_n2[0]);
    if (o !== pend_ovf[0]) report("overflow", o, pend_ovf[0]);
    if (l !== pend_last[0]) report("last", l, pend_last[0]);
    void'(pend_q.pop_front()); void'(pend_t1.pop_front()); void'(pend_c1.pop_front());
    void'(pend_t2.pop_front()); void'(pend_c2.pop_front()); void'(pend_both.pop_front());
    void'(pend_n1.pop_front()); void'(pend_n2.pop_front()); void'(pend_ovf.pop_front());
    void'(pend_last.pop_front());
  endtask
endclass

module tb_top;
  import ppcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  command;
  logic [31:0] query_id;
  logic [31:0] doc_id;
  logic [31:0] concept_id;
  logic [3:0]  concept_type;
  logic        strobe;
  logic [31:0] out_query_id;
  logic [3:0]  first_type;
  logic [31:0] first_concept;
  logic [3:0]  second_type;
  logic [31:0] second_concept;
  logic [8:0]  both_count;
  logic [8:0]  first_count;
  logic [8:0]  second_count;
  logic        overflow;
  logic        last;

  cooc_scoreboard sb;
  int burst_left;
  int items_sent;
  logic [31:0] doc_cursor;

  pairwise_posting_cooccurrence_counter u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .query_id(query_id), .doc_id(doc_id), .concept_id(concept_id),
    .concept_type(concept_type), .strobe(strobe), .out_query_id(out_query_id),
    .first_type(first_type), .first_concept(first_concept), .second_type(second_type),
    .second_concept(second_concept), .both_count(both_count), .first_count(first_count),
    .second_count(second_count), .overflow(overflow), .last(last)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // result monitor: a word is taken at the edge that ends its strobe cycle
  always @(posedge clk) begin
    if (!rst && strobe)
      sb.check_word(out_query_id, first_type, first_concept, second_type, second_concept,
                    both_count, first_count, second_count, overflow, last);
  end

  // send one command word; bursts with random gaps between them
  task send_word(cmd_t cmd, logic [31:0] qid, logic [31:0] doc, logic [31:0] cid,
                 logic [3:0] ctype);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    start <= 1'b1;
    command <= cmd; query_id <= qid; doc_id <= doc; concept_id <= cid;
    concept_type <= ctype;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(cmd, qid, doc, cid, ctype);
    burst_left--;
    items_sent++;
  endtask

  // raw command code, for the unused codes
  task send_raw(logic [2:0] code);
    start <= 1'b1;
    command <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(code, query_id, doc_id, concept_id, concept_type);
    items_sent++;
  endtask

  // ascending run of doc ids with random steps, sometimes duplicates
  function logic [31:0] next_doc();
    doc_cursor = doc_cursor + $urandom_range(0, 3);
    return doc_cursor;
  endfunction

  // one well-formed query with random content
  task random_query();
    int nrel, ncon, npost;
    send_word(CMD_NEW_QUERY, $urandom, 0, 0, 0);
    doc_cursor = $urandom_range(0, 20);
    nrel = $urandom_range(0, 12);
    for (int k = 0; k < nrel; k++)
      send_word(CMD_ADD_REL, $urandom, next_doc(), $urandom, 4'($urandom));
    ncon = $urandom_range(0, 5);
    for (int c = 0; c < ncon; c++) begin
      send_word(CMD_BEGIN, $urandom, $urandom, $urandom, 4'($urandom));
      doc_cursor = $urandom_range(0, 20);
      npost = $urandom_range(0, 8);
      for (int k = 0; k < npost; k++)
        send_word(CMD_ADD_POST, $urandom, ($urandom_range(9) == 0) ? $urandom : next_doc(),
                  $urandom, 4'($urandom));
    end
    // noise: a stray word now and then
    if ($urandom_range(3) == 0) send_raw(3'($urandom));
    send_word(CMD_COMPUTE, $urandom, $urandom, $urandom, 4'($urandom));
  endtask

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new();
    burst_left = 0;
    items_sent = 0;
    rst <= 1'b1; start <= 1'b0; command <= CMD_NEW_QUERY; query_id <= '0; doc_id <= '0;
    concept_id <= '0; concept_type <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: compute with no concepts, posting before any concept, extremes
    send_word(CMD_COMPUTE, 0, 0, 0, 0);
    send_word(CMD_ADD_POST, 0, 32'd5, 0, 0);
    send_word(CMD_NEW_QUERY, 32'hFFFF_FFFF, 0, 0, 0);
    send_word(CMD_ADD_REL, 0, 32'd0, 0, 0);
    send_word(CMD_ADD_REL, 0, 32'd7, 0, 0);
    send_word(CMD_ADD_REL, 0, 32'hFFFF_FFFF, 0, 0);
    send_word(CMD_BEGIN, 0, 0, 32'hFFFF_FFFF, 4'hF);
    send_word(CMD_ADD_POST, 0, 32'd0, 0, 0);
    send_word(CMD_ADD_POST, 0, 32'hFFFF_FFFF, 0, 0);
    send_word(CMD_BEGIN, 0, 0, 32'd0, 4'h0);
    send_word(CMD_ADD_POST, 0, 32'd7, 0, 0);
    send_word(CMD_ADD_POST, 0, 32'd0, 0, 0);
    send_word(CMD_COMPUTE, 0, 0, 0, 0);
    send_raw(3'd5); send_raw(3'd6); send_raw(3'd7);
    // one concept only: compute gives nothing
    send_word(CMD_NEW_QUERY, 32'h0, 0, 0, 0);
    send_word(CMD_BEGIN, 0, 0, 32'h1234, 4'h3);
    send_word(CMD_COMPUTE, 0, 0, 0, 0);

    // full tables: relevant list overflow, nine concepts
    send_word(CMD_NEW_QUERY, $urandom, 0, 0, 0);
    for (int k = 0; k < 257; k++) send_word(CMD_ADD_REL, 0, 2 * k, 0, 0);
    for (int c = 0; c < 9; c++) begin
      send_word(CMD_BEGIN, 0, 0, $urandom, 4'($urandom));
      for (int k = 0; k < 3 + c; k++) send_word(CMD_ADD_POST, 0, k * (c + 1), 0, 0);
    end
    send_word(CMD_COMPUTE, 0, 0, 0, 0);
    send_word(CMD_NEW_QUERY, $urandom, 0, 0, 0);
    send_word(CMD_ADD_REL, 0, 32'd100, 0, 0);
    send_word(CMD_BEGIN, 0, 0, 1, 1);
    for (int k = 0; k < 20; k++) send_word(CMD_ADD_POST, 0, k, 0, 0);
    send_word(CMD_BEGIN, 0, 0, 2, 2);
    send_word(CMD_ADD_POST, 0, 32'd100, 0, 0);
    send_word(CMD_COMPUTE, 0, 0, 0, 0);

    // random queries
    while (items_sent < 410) random_query();

    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
